// ----- hdl/dwg_pkg.sv -----
// Shared types, constants and tables for the DDS waveform DAC generator.
package dwg_pkg;

	localparam int INDEX_BITS = 12;
	localparam int PHASE_BITS = 32;
	localparam int QBITS      = INDEX_BITS - 2;
	localparam int T_SHIFT    = 30 - QBITS;
	localparam int T_W        = 31;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int STEP_BITS  = (PHASE_BITS < CFG_DATA_W) ? PHASE_BITS : CFG_DATA_W;

	localparam int AMP_W      = 14;
	localparam int MID_W      = 12;
	localparam int GAIN_W     = 16;
	localparam int TGT_W      = 15;
	localparam int ACC_W      = 34;
	localparam int MB_W       = 32;
	localparam int PROD_W     = ACC_W + MB_W;
	localparam int CODE_W     = 12;
	localparam int WORD_W     = 16;
	localparam int PIDX_W     = 12;

	localparam int                      HORNER_STEPS = 5;
	localparam int                      COEF_IDX_W   = 3;
	localparam logic signed [ACC_W-1:0] HORNER_COEF [HORNER_STEPS + 1] = '{
		ACC_W'(-3864),
		ACC_W'(172272),
		ACC_W'(-5026995),
		ACC_W'(85569306),
		ACC_W'(-693598668),
		ACC_W'(1686629713)
	};

	localparam logic [WORD_W-1:0] DAC_CTRL   = 16'h3000;
	localparam logic [CODE_W-1:0] CODE_MAX   = 12'hFFF;
	localparam logic [MID_W-1:0]  MID_RESET  = 12'd2011;
	localparam logic [GAIN_W-1:0] GPOS_RESET = 16'd25944;
	localparam logic [GAIN_W-1:0] GNEG_RESET = 16'd27536;

	typedef enum logic [1:0] {
		MODE_DC,
		MODE_SINE,
		MODE_SAW,
		MODE_SQUARE
	} wave_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVE_MODE,
		REG_PHASE_STEP,
		REG_AMPLITUDE,
		REG_MID_CODE,
		REG_GAIN_POS,
		REG_GAIN_NEG
	} reg_idx_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_TT,
		MUL_ACC_T2,
		MUL_ACC_T,
		MUL_ACC_AMP,
		MUL_AMP_SAW,
		MUL_TGT_GAIN
	} mul_sel_t;

	typedef enum logic [3:0] {
		POST_NONE,
		POST_T2,
		POST_HORNER,
		POST_SINE,
		POST_TGT_SINE,
		POST_TGT_SAW,
		POST_TGT_DC,
		POST_TGT_SQUARE,
		POST_OUT
	} post_t;

	typedef struct packed {
		wave_mode_t               wave_mode;
		logic [STEP_BITS-1:0]     phase_step;
		logic signed [AMP_W-1:0]  amplitude_mv;
		logic [MID_W-1:0]         mid_code;
		logic [GAIN_W-1:0]        gain_pos;
		logic [GAIN_W-1:0]        gain_neg;
	} cfg_t;

	typedef struct packed {
		logic                  accept;
		mul_sel_t              mul_sel;
		post_t                 post;
		logic [COEF_IDX_W-1:0] coef_sel;
	} cmd_t;

endpackage

// ----- hdl/dwg_cfg_regs.sv -----
// Configuration register file for the DDS waveform DAC generator.
module dwg_cfg_regs
	import dwg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave_mode    <= MODE_DC;
			cfg_q.phase_step   <= '0;
			cfg_q.amplitude_mv <= '0;
			cfg_q.mid_code     <= MID_RESET;
			cfg_q.gain_pos     <= GPOS_RESET;
			cfg_q.gain_neg     <= GNEG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_WAVE_MODE:  cfg_q.wave_mode    <= wave_mode_t'(cfg_data[1:0]);
				REG_PHASE_STEP: cfg_q.phase_step   <= cfg_data[STEP_BITS-1:0];
				REG_AMPLITUDE:  cfg_q.amplitude_mv <= $signed(cfg_data[AMP_W-1:0]);
				REG_MID_CODE:   cfg_q.mid_code     <= cfg_data[MID_W-1:0];
				REG_GAIN_POS:   cfg_q.gain_pos     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_NEG:   cfg_q.gain_neg     <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/dwg_ctrl.sv -----
// Controller that sequences the shared multiplier for each sample.
module dwg_ctrl
	import dwg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  wave_mode_t wave_mode,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_T2_MUL,
		S_T2_POST,
		S_H_MUL,
		S_H_POST,
		S_F_MUL,
		S_F_POST,
		S_A_MUL,
		S_A_POST,
		S_TGT,
		S_G_MUL,
		S_G_POST
	} state_t;

	state_t                state_q;
	logic [COEF_IDX_W-1:0] cnt_q;
	logic                  out_valid_q;
	logic                  out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.accept   = in_valid && in_ready;
		cmd.mul_sel  = MUL_NONE;
		cmd.post     = POST_NONE;
		cmd.coef_sel = cnt_q;
		case (state_q)
			S_T2_MUL:  cmd.mul_sel = MUL_TT;
			S_T2_POST: cmd.post    = POST_T2;
			S_H_MUL:   cmd.mul_sel = MUL_ACC_T2;
			S_H_POST:  cmd.post    = POST_HORNER;
			S_F_MUL:   cmd.mul_sel = MUL_ACC_T;
			S_F_POST:  cmd.post    = POST_SINE;
			S_A_MUL:   cmd.mul_sel = (wave_mode == MODE_SINE) ? MUL_ACC_AMP : MUL_AMP_SAW;
			S_A_POST:  cmd.post    = (wave_mode == MODE_SINE) ? POST_TGT_SINE : POST_TGT_SAW;
			S_TGT:     cmd.post    = (wave_mode == MODE_SQUARE) ? POST_TGT_SQUARE : POST_TGT_DC;
			S_G_MUL:   cmd.mul_sel = MUL_TGT_GAIN;
			S_G_POST:  cmd.post    = out_free ? POST_OUT : POST_NONE;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (wave_mode)
							MODE_SINE: state_q <= S_T2_MUL;
							MODE_SAW:  state_q <= S_A_MUL;
							default:   state_q <= S_TGT;
						endcase
					end
				end
				S_T2_MUL:  state_q <= S_T2_POST;
				S_T2_POST: begin
					cnt_q   <= COEF_IDX_W'(1);
					state_q <= S_H_MUL;
				end
				S_H_MUL:   state_q <= S_H_POST;
				S_H_POST: begin
					if (cnt_q == COEF_IDX_W'(HORNER_STEPS)) begin
						state_q <= S_F_MUL;
					end else begin
						cnt_q   <= cnt_q + COEF_IDX_W'(1);
						state_q <= S_H_MUL;
					end
				end
				S_F_MUL:   state_q <= S_F_POST;
				S_F_POST:  state_q <= S_A_MUL;
				S_A_MUL:   state_q <= S_A_POST;
				S_A_POST:  state_q <= S_G_MUL;
				S_TGT:     state_q <= S_G_MUL;
				S_G_MUL:   state_q <= S_G_POST;
				S_G_POST: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/dwg_datapath.sv -----
// Datapath: phase accumulator, shared multiplier, sine polynomial and DAC code stage.
module dwg_datapath
	import dwg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	input  logic                advance,
	output logic [WORD_W-1:0]   dac_word,
	output logic [PIDX_W-1:0]   phase_index,
	output logic                clipped
);

	localparam logic [INDEX_BITS-1:0]    HALF      = INDEX_BITS'(1) << (INDEX_BITS - 1);
	localparam logic [QBITS:0]           QUARTER   = (QBITS + 1)'(1) << QBITS;
	localparam logic signed [PROD_W-1:0] Q30_BIAS  = PROD_W'((64'sd1 <<< 30) - 64'sd1);
	localparam logic signed [ACC_W-1:0]  RND_Q15   = ACC_W'(16384);
	localparam logic signed [ACC_W-1:0]  SINE_MAX  = ACC_W'(32767);
	localparam int                       RAW_W     = 17;

	logic [PHASE_BITS-1:0]        phase_acc_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [MB_W-1:0]       t2_q;
	logic signed [TGT_W-1:0]      target_q;
	logic [WORD_W-1:0]            dac_word_q;
	logic [PIDX_W-1:0]            phase_index_q;
	logic                         clipped_q;

	logic [INDEX_BITS-1:0]        idx;
	logic [1:0]                   quad;
	logic [QBITS:0]               pos;
	logic [T_W-1:0]               t;
	logic signed [ACC_W-1:0]      mul_a;
	logic signed [MB_W-1:0]       mul_b;
	logic signed [PROD_W-1:0]     mul_p;
	logic signed [ACC_W-1:0]      prod_q30;
	logic signed [ACC_W-1:0]      sine_rnd;
	logic signed [ACC_W-1:0]      sine_val;
	logic signed [TGT_W-1:0]      amp_t;
	logic signed [INDEX_BITS:0]   saw_w;
	logic signed [TGT_W:0]        off;
	logic signed [RAW_W-1:0]      raw;
	logic [CODE_W-1:0]            code;
	logic                         clip;

	function automatic logic signed [ACC_W-1:0] trunc_q30(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] bias;
		logic signed [PROD_W-1:0] sh;
		bias = '0;
		if (p[PROD_W-1]) begin
			bias = Q30_BIAS;
		end
		sh = (p + bias) >>> 30;
		return sh[ACC_W-1:0];
	endfunction

	function automatic logic signed [PROD_W-1:0] round_shift(
		input logic signed [PROD_W-1:0] v,
		input int unsigned              s
	);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r   = (mag + (PROD_W'(1) << (s - 1))) >> s;
		return v[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

	assign idx   = phase_acc_q[PHASE_BITS-1 -: INDEX_BITS];
	assign quad  = idx[INDEX_BITS-1 -: 2];
	assign pos   = quad[0] ? (QUARTER - {1'b0, idx[QBITS-1:0]}) : {1'b0, idx[QBITS-1:0]};
	assign t     = {pos, {T_SHIFT{1'b0}}};
	assign amp_t = TGT_W'(cfg.amplitude_mv);
	assign saw_w = $signed({1'b0, HALF}) - $signed({1'b0, idx});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_TT: begin
				mul_a = ACC_W'($signed({1'b0, t}));
				mul_b = $signed({1'b0, t});
			end
			MUL_ACC_T2: begin
				mul_a = acc_q;
				mul_b = t2_q;
			end
			MUL_ACC_T: begin
				mul_a = acc_q;
				mul_b = $signed({1'b0, t});
			end
			MUL_ACC_AMP: begin
				mul_a = acc_q;
				mul_b = MB_W'(cfg.amplitude_mv);
			end
			MUL_AMP_SAW: begin
				mul_a = ACC_W'(cfg.amplitude_mv);
				mul_b = MB_W'(saw_w);
			end
			MUL_TGT_GAIN: begin
				mul_a = ACC_W'(target_q);
				mul_b = target_q[TGT_W-1] ? MB_W'($signed({1'b0, cfg.gain_neg}))
				                          : MB_W'($signed({1'b0, cfg.gain_pos}));
			end
			default: ;
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign prod_q30 = trunc_q30(prod_q);

	always_comb begin
		sine_rnd = prod_q30[ACC_W-1] ? RND_Q15 : ((prod_q30 + RND_Q15) >>> 15);
		if (prod_q30[ACC_W-1]) begin
			sine_rnd = '0;
		end
		if (sine_rnd > SINE_MAX) begin
			sine_rnd = SINE_MAX;
		end
		sine_val = quad[1] ? -sine_rnd : sine_rnd;
	end

	always_comb begin
		off  = (TGT_W + 1)'(round_shift(prod_q, 16));
		raw  = RAW_W'($signed({1'b0, cfg.mid_code})) - RAW_W'(off);
		clip = 1'b0;
		code = raw[CODE_W-1:0];
		if (raw[RAW_W-1]) begin
			code = '0;
			clip = 1'b1;
		end else if (raw > RAW_W'($signed({1'b0, CODE_MAX}))) begin
			code = CODE_MAX;
			clip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
		end else if (cmd.accept && advance) begin
			phase_acc_q <= phase_acc_q + PHASE_BITS'(cfg.phase_step);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_sel != MUL_NONE) begin
			prod_q <= mul_p;
		end
		case (cmd.post)
			POST_T2: begin
				t2_q  <= MB_W'(prod_q30);
				acc_q <= HORNER_COEF[0];
			end
			POST_HORNER:     acc_q    <= HORNER_COEF[cmd.coef_sel] + prod_q30;
			POST_SINE:       acc_q    <= sine_val;
			POST_TGT_SINE:   target_q <= TGT_W'(round_shift(prod_q, 15));
			POST_TGT_SAW:    target_q <= TGT_W'(round_shift(prod_q, INDEX_BITS - 1));
			POST_TGT_DC:     target_q <= amp_t;
			POST_TGT_SQUARE: target_q <= idx[INDEX_BITS-1] ? -amp_t : amp_t;
			POST_OUT: begin
				dac_word_q    <= DAC_CTRL | WORD_W'(code);
				phase_index_q <= PIDX_W'(idx);
				clipped_q     <= clip;
			end
			default: ;
		endcase
	end

	assign dac_word    = dac_word_q;
	assign phase_index = phase_index_q;
	assign clipped     = clipped_q;

endmodule

// ----- hdl/dds_waveform_dac_generator_unit.sv -----
// Top level of the DDS waveform DAC generator.
//
//   channel  handshake               payload
//   input    in_valid / in_ready     advance
//   output   out_valid / out_ready   dac_word, phase_index, clipped
//   config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each sample runs in turn through the single shared multiplier: every product
// is registered before use; dc and square need only the gain product, sawtooth
// adds the amplitude product, and the sine polynomial needs seven products first.
// The result register lets the next transfer in while a sample waits; a stalled
// output holds the finished sample in its last step until out_ready.
// Reset clears the phase accumulator and loads the register defaults; no clearing pass.
module dds_waveform_dac_generator_unit
	import dwg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  advance,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_W-1:0]     dac_word,
	output logic [PIDX_W-1:0]     phase_index,
	output logic                  clipped
);

	cfg_t cfg;
	cmd_t cmd;

	dwg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dwg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.wave_mode (cfg.wave_mode),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	dwg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.advance     (advance),
		.dac_word    (dac_word),
		.phase_index (phase_index),
		.clipped     (clipped)
	);

endmodule
